// ===== rtl/lmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared types and constants for the LED matrix frame scanout block.
// ----------------------------------------------------------------------------
package lmfs_pkg;

  localparam int unsigned ROWS = 8;
  localparam logic [7:0] DIGIT_BASE = 8'd1;

  typedef enum logic [2:0] {
    OP_SET_PIXEL = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_REFRESH   = 3'd2,
    OP_SEND_ONE  = 3'd3,
    OP_SEND_ALL  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_REFRESH,
    ST_SEND
  } state_t;

  // Frame store access controls
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } store_ctl_t;

endpackage

// ===== rtl/lmfs_ram.sv =====
// ----------------------------------------------------------------------------
// lmfs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lmfs_store.sv =====
// ----------------------------------------------------------------------------
// lmfs_store
// Frame store: RAM plus per-entry valid bits, so reset and clear just drop
// the valid bits and an entry never written since reads as zero.
// ----------------------------------------------------------------------------
module lmfs_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  lmfs_pkg::store_ctl_t ctl,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  logic [7:0]          wr_data,
  output logic [7:0]          rd_data
);
  import lmfs_pkg::*;

  logic [DEPTH-1:0] vld;
  logic             vld_q;
  logic [7:0]       ram_q;

  lmfs_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.wr),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (ctl.rd),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (ctl.clr) begin
        vld <= '0;
      end else if (ctl.wr) begin
        vld[wr_addr] <= 1'b1;
      end
      if (ctl.rd) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? ram_q : 8'd0;

  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst) !(ctl.rd && ctl.wr))
    else $error("frame store read and write in the same cycle");
  a_no_clr_wr: assert property (@(posedge clk) disable iff (rst) !(ctl.clr && ctl.wr))
    else $error("frame store clear and write in the same cycle");
  a_clr_zero: assert property (@(posedge clk) disable iff (rst) ctl.clr |=> (vld == '0))
    else $error("valid bits not cleared");

endmodule

// ===== rtl/led_matrix_frame_scanout.sv =====
// ----------------------------------------------------------------------------
// led_matrix_frame_scanout
// Frame store and word sequencer for a daisy chain of 8x8 LED matrix modules.
//
// Requests enter on in_valid/in_ready; each carries an opcode and its fields.
// Words leave on out_valid/out_ready, one per 16-bit word shifted into the
// chain, farthest module first; frame_end marks the word before chip select
// rises and last marks the final word of a request.
// layout_select is written on cfg_valid/cfg_ready; the user must write it
// only while the block is idle, the block does not enforce it. Set pixel
// reads the store entry, then writes it back. Clear drops all entry valid
// bits. Refresh reads the store at one entry per word and emits 8*MODULES
// words, each via the read stage and output register, one per cycle while
// out_ready stays high. Send one and send all emit MODULES words at one per
// cycle while out_ready stays high. The next request is taken once the last
// word of the current one has left the read stage. A stalled receiver holds
// the output register and the read stage; the sequencer waits and nothing is
// dropped. Reset empties the store and the output, and selects layout 0.
// ----------------------------------------------------------------------------
module led_matrix_frame_scanout #(
  parameter int unsigned MODULES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       layout_select,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] opcode,
  input  logic [4:0] pixel_x,
  input  logic [2:0] pixel_y,
  input  logic       pixel_on,
  input  logic [1:0] module_index,
  input  logic [7:0] reg_address,
  input  logic [7:0] reg_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] word_register,
  output logic [7:0] word_data,
  output logic       frame_end,
  output logic       last
);
  import lmfs_pkg::*;

  localparam int unsigned DEPTH = MODULES * ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned MW    = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam logic [MW-1:0] MOD_TOP = MW'(MODULES - 1);
  localparam logic [2:0]    ROW_TOP = 3'(ROWS - 1);

  state_t     state, state_next;
  store_ctl_t ctl;

  logic          layout;
  logic [2:0]    row;
  logic [MW-1:0] mod;
  logic          send_all;
  logic [1:0]    tgt;
  logic [7:0]    addr_b, val_b;
  logic [AW-1:0] pix_addr;
  logic [7:0]    pix_mask;
  logic          pix_on;

  // read stage: one word waiting for the output register
  logic       pend, pend_mem, pend_fend, pend_last;
  logic [7:0] pend_reg, pend_data;

  logic          accept, issue, move;
  logic [7:0]    st_rd_data, wr_data;
  logic [AW-1:0] rd_addr;
  logic [MW+2:0] ref_addr;
  logic [7:0]    px_mod, px_mod_eff;
  logic [MW+2:0] px_addr_full;
  logic          px_in_range, hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout <= 1'b0;
    end else if (cfg_valid) begin
      layout <= layout_select;
    end
  end

  assign move     = pend && (!out_valid || out_ready);
  assign in_ready = (state == ST_IDLE) && (!pend || move);
  assign accept   = in_valid && in_ready;

  // pixel address decode
  assign px_mod       = 8'(pixel_x[4:3]);
  assign px_in_range  = px_mod < 8'(MODULES);
  assign px_mod_eff   = layout ? (8'(MODULES - 1) - px_mod) : px_mod;
  assign px_addr_full = {px_mod_eff[MW-1:0], pixel_y};

  assign ref_addr = {mod, row};
  assign hit      = send_all || (8'(mod) == 8'(tgt));

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    ctl        = '0;
    rd_addr    = pix_addr;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (opcode == OP_SET_PIXEL) begin
            if (px_in_range) begin
              state_next = ST_PIX_RD;
            end
          end else if (opcode == OP_CLEAR) begin
            ctl.clr = 1'b1;
          end else if (opcode == OP_REFRESH) begin
            state_next = ST_REFRESH;
          end else if (opcode == OP_SEND_ONE || opcode == OP_SEND_ALL) begin
            state_next = ST_SEND;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PIX_RD: begin
        ctl.rd     = 1'b1;
        state_next = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        ctl.wr     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_REFRESH: begin
        rd_addr = ref_addr[AW-1:0];
        if (!pend || move) begin
          issue  = 1'b1;
          ctl.rd = 1'b1;
          if (mod == '0 && row == ROW_TOP) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SEND: begin
        if (!pend || move) begin
          issue = 1'b1;
          if (mod == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign wr_data = pix_on ? (st_rd_data | pix_mask) : (st_rd_data & ~pix_mask);

  lmfs_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .rd_addr(rd_addr),
    .wr_addr(pix_addr),
    .wr_data(wr_data),
    .rd_data(st_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request fields and sequence counters
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_addr <= px_addr_full[AW-1:0];
      pix_mask <= 8'h80 >> pixel_x[2:0];
      pix_on   <= pixel_on;
      send_all <= (opcode == OP_SEND_ALL);
      tgt      <= module_index;
      addr_b   <= reg_address;
      val_b    <= reg_value;
      row      <= 3'd0;
      mod      <= MOD_TOP;
    end else if (issue) begin
      if (mod == '0) begin
        mod <= MOD_TOP;
        row <= row + 3'd1;
      end else begin
        mod <= mod - MW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (issue) begin
      pend <= 1'b1;
    end else if (move) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_fend <= (mod == '0);
      if (state == ST_REFRESH) begin
        pend_mem  <= 1'b1;
        pend_reg  <= DIGIT_BASE + 8'(row);
        pend_data <= 8'd0;
        pend_last <= (mod == '0) && (row == ROW_TOP);
      end else begin
        pend_mem  <= 1'b0;
        pend_reg  <= hit ? addr_b : 8'd0;
        pend_data <= hit ? val_b : 8'd0;
        pend_last <= (mod == '0);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      word_register <= pend_reg;
      word_data     <= pend_mem ? st_rd_data : pend_data;
      frame_end     <= pend_fend;
      last          <= pend_last;
    end
  end

  a_pix_no_pend: assert property (@(posedge clk) disable iff (rst)
      (state == ST_PIX_RD || state == ST_PIX_WR) |-> !pend)
    else $error("pixel access while a read word is still held");
  a_last_fend: assert property (@(posedge clk) disable iff (rst)
      (out_valid && last) |-> frame_end)
    else $error("last word does not end a frame");
  a_pix_order: assert property (@(posedge clk) disable iff (rst)
      (state == ST_PIX_WR) |-> ($past(state) == ST_PIX_RD))
    else $error("pixel write without preceding read");
  a_issue_room: assert property (@(posedge clk) disable iff (rst)
      (pend && !move) |-> !issue)
    else $error("read stage overwritten");

endmodule
